FILE: src/pfi_pkg.sv
package pfi_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int TAP_W      = 18;
  localparam int PROD_W     = SAMPLE_W + TAP_W;
  localparam int CH_IDX_W   = 3;
  localparam int PHASE_W    = 3;
  localparam int FRAC_SHIFT = 17;
  localparam int OUT_MAX    = 8388607;
  localparam int OUT_MIN    = -8388608;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } pfi_state_e;

  typedef enum logic [0:0] {
    REG_FACTOR_SHIFT    = 1'b0,
    REG_ACTIVE_CHANNELS = 1'b1
  } pfi_reg_e;

  typedef struct packed {
    logic issue;
    logic clr;
  } mac_ctrl_t;

endpackage

FILE: src/pfi_tap_rom.sv
module pfi_tap_rom #(
  parameter int TAPS_PER_PHASE = 16,
  parameter int MAX_SHIFT      = 3,
  parameter int ADDR_W         = 7
) (
  input  logic                                clk_i,
  input  logic [1:0]                          shift_i,
  input  logic [ADDR_W-1:0]                   addr_i,
  output logic signed [pfi_pkg::TAP_W-1:0]    tap_o
);
  import pfi_pkg::*;

  localparam int PL = TAPS_PER_PHASE + 1;
  localparam longint Q30        = 64'sd1073741824;
  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Truncating division of non-negative values, shift and subtract.
  function automatic longint udiv(longint num, longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((num >>> b) & longint'(1));
      if (r >= den) begin
        r = r - den;
        q = q | (longint'(1) <<< b);
      end
    end
    return q;
  endfunction

  // Signed division, rounded toward zero.
  function automatic longint sdiv(longint num, longint den);
    longint q;
    q = udiv((num < 0) ? -num : num, (den < 0) ? -den : den);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  // Remainder with the sign of the dividend.
  function automatic longint smod(longint num, longint den);
    return num - sdiv(num, den) * den;
  endfunction

  // Taylor sine on [0, pi/2], Q30.
  function automatic longint sine_q30(longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) / Q30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      term = sdiv(-((term * x2) / Q30), longint'((2 * k) * (2 * k + 1)));
      sum  = sum + term;
    end
    return sum;
  endfunction

  // sin(2*pi*num/den), Q30.
  function automatic longint sine_turns(longint num, longint den);
    longint m;
    longint q4;
    longint quad;
    longint rem;
    longint s;
    m = smod(num, den);
    if (m < 0) m = m + den;
    q4   = 4 * m;
    quad = sdiv(q4, den);
    rem  = q4 - quad * den;
    if (quad[0]) rem = den - rem;
    s = sine_q30(sdiv(rem * HALF_PI_Q30, den));
    return (quad >= 2) ? -s : s;
  endfunction

  // Windowed sinc tap before normalization.
  function automatic longint raw_tap(longint f, longint i);
    longint span;
    longint n;
    longint sinc;
    longint win;
    span = longint'(TAPS_PER_PHASE) * f;
    n    = i - (span >>> 1);
    if (n == 0) sinc = sdiv(92 * Q30, 100 * f);
    else sinc = sdiv(sine_turns(46 * n, 100 * f) * Q30, PI_Q30 * n);
    win = (42 * Q30) / 100
        - sine_turns(4 * i + span, 4 * span) / 2
        + (8 * sine_turns(8 * i + span, 4 * span)) / 100;
    return (sinc * win) / Q30;
  endfunction

  // Sum of the raw taps for factor 2^s, used to normalize to unit DC gain.
  function automatic longint tap_sum(int s);
    longint f;
    longint len;
    longint sum;
    f   = longint'(1) << s;
    len = longint'(TAPS_PER_PHASE) * f + 1;
    sum = 0;
    for (longint t = 0; t < len; t++) sum = sum + raw_tap(f, t);
    if (sum <= 0) sum = Q30;
    return sum;
  endfunction

  // Tap at slot j of phase p for factor 2^s, Q1.17.
  function automatic longint tap_value(int s, int p, int j, longint sum);
    longint f;
    longint len;
    longint i;
    longint v;
    longint q;
    f   = longint'(1) << s;
    len = longint'(TAPS_PER_PHASE) * f + 1;
    i   = longint'(p) + longint'(PL - 1 - j) * f;
    if (i >= len) return 0;
    v = raw_tap(f, i) * (longint'(1) << 17);
    if (v >= 0) q = sdiv(v + (sum >>> 1), sum);
    else q = -sdiv(-v + (sum >>> 1), sum);
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    return q;
  endfunction

  logic signed [TAP_W-1:0] tab_sel [4];

  assign tab_sel[0] = '0;

  for (genvar s = 1; s < 4; s++) begin : g_shift
    if (s <= MAX_SHIFT) begin : g_tab
      localparam int     DEPTH_S = (1 << s) * PL;
      localparam int     DW      = $clog2(DEPTH_S);
      localparam longint TAP_SUM = tap_sum(s);
      logic signed [TAP_W-1:0] rom [DEPTH_S];
      for (genvar p = 0; p < (1 << s); p++) begin : g_phase
        for (genvar j = 0; j < PL; j++) begin : g_entry
          localparam logic signed [TAP_W-1:0] TAP_VAL = TAP_W'(tap_value(s, p, j, TAP_SUM));
          assign rom[p * PL + j] = TAP_VAL;
        end
      end
      assign tab_sel[s] = rom[addr_i[DW-1:0]];
    end else begin : g_none
      assign tab_sel[s] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_o <= tab_sel[shift_i];
  end

endmodule

FILE: src/pfi_hist_mem.sv
module pfi_hist_mem #(
  parameter int DEPTH  = 136,
  parameter int ADDR_W = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   clr_i,
  input  logic                                   we_i,
  input  logic [ADDR_W-1:0]                      waddr_i,
  input  logic signed [pfi_pkg::SAMPLE_W-1:0]    wdata_i,
  input  logic [ADDR_W-1:0]                      raddr_i,
  output logic signed [pfi_pkg::SAMPLE_W-1:0]    rdata_o
);
  import pfi_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid_q;
  logic                       rvalid_q;
  logic signed [SAMPLE_W-1:0] rdata_q;

  // Entries never written since reset or the last clear read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[raddr_i];
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

FILE: src/pfi_mac.sv
module pfi_mac #(
  parameter int TAPS_PER_PHASE = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pfi_pkg::mac_ctrl_t                    ctrl_i,
  input  logic [1:0]                            shift_i,
  input  logic signed [pfi_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic signed [pfi_pkg::TAP_W-1:0]      tap_i,
  output logic                                  busy_o,
  output logic signed [pfi_pkg::SAMPLE_W-1:0]   result_o
);
  import pfi_pkg::*;

  localparam int PL    = TAPS_PER_PHASE + 1;
  localparam int ACC_W = PROD_W + $clog2(PL);
  localparam int SC_W  = ACC_W + 3;

  logic                     v1_q;
  logic                     v2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [SC_W-1:0]   scaled;
  logic signed [SC_W-1:0]   rounded;

  // Read data and tap arrive in the cycle after issue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= sample_i * tap_i;
    end
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign busy_o = v1_q | v2_q;

  // Scale by the factor, round half up to Q1.23, saturate.
  always_comb begin
    scaled  = SC_W'(acc_q) <<< shift_i;
    rounded = (scaled + (SC_W'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    if (rounded > SC_W'(OUT_MAX)) begin
      result_o = SAMPLE_W'(OUT_MAX);
    end else if (rounded < SC_W'(OUT_MIN)) begin
      result_o = SAMPLE_W'(OUT_MIN);
    end else begin
      result_o = rounded[SAMPLE_W-1:0];
    end
  end

endmodule

FILE: src/polyphase_fir_interpolator.sv
// Multichannel polyphase FIR interpolator. Each input request carries one Q1.23 sample
// (tdata) for the channel in tuser; tlast marks the end of a host block. The sample enters
// that channel's history of TAPS_PER_PHASE+1 samples, then one result per phase is sent
// (2, 4 or 8 per input for factor_shift 1, 2, 3), each the dot product of the history with
// the phase's Blackman-windowed sinc taps, scaled by the factor, rounded and saturated.
// The last result of a run carries tlast and, in tuser, the block end flag. factor_shift 0
// passes samples straight through; channels at or above active_channels are dropped.
// One multiply-accumulate unit does all the work, one tap per cycle: an input is first
// written into its channel's history, then each phase issues its taps and drains the MAC
// pipeline, paced by the single history memory read port; bypass skips history and MAC.
// Any register write clears all sample histories. Input is not accepted while an item is
// in progress; a finished result waits for a free output register, stalling the sequencer.
module polyphase_fir_interpolator #(
  parameter int TAPS_PER_PHASE = 16,
  parameter int MAX_CHANNELS   = 8,
  parameter int MAX_FACTOR     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] in_sample
  input  logic [2:0]  s_axis_tuser,   // [2:0] channel_index
  input  logic        s_axis_tlast,
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [23:0] out_sample
  output logic [6:0]  m_axis_tuser,   // [2:0] out_channel, [5:3] phase_index, [6] block_end
  output logic        m_axis_tlast,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pfi_pkg::*;

  localparam int PL        = TAPS_PER_PHASE + 1;
  localparam int MAX_SHIFT = $clog2(MAX_FACTOR + 1) - 1;
  localparam int DEPTH     = MAX_CHANNELS * PL;
  localparam int AW        = $clog2(DEPTH);
  localparam int IDX_W     = $clog2(PL);
  localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TAW       = $clog2((1 << MAX_SHIFT) * PL);

  pfi_state_e state_q, state_d;

  logic [1:0]  fs_q;
  logic [3:0]  act_q;
  logic        cfg_we;
  logic [1:0]  eff_shift;
  logic [4:0]  act_lim;
  logic        in_active;
  logic        accept;
  logic        last_phase;
  logic        out_load;

  logic [IDX_W-1:0] wp_q [MAX_CHANNELS];
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] pos_next;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] start_q;
  logic [IDX_W-1:0] j_q;
  logic [AW-1:0]    base_q;
  logic [TAW-1:0]   tap_addr_q;
  logic [PHASE_W-1:0] phase_q;
  logic               bypass_q;

  logic [CH_IDX_W-1:0]        ch_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       eob_q;

  logic                       hist_we;
  logic signed [SAMPLE_W-1:0] hist_rdata;
  logic signed [TAP_W-1:0]    tap;
  mac_ctrl_t                  mac_ctrl;
  logic                       mac_busy;
  logic signed [SAMPLE_W-1:0] mac_result;

  logic                       out_valid_q;
  logic [SAMPLE_W-1:0]        out_sample_q;
  logic [CH_IDX_W-1:0]        out_ch_q;
  logic [PHASE_W-1:0]         out_phase_q;
  logic                       out_last_q;
  logic                       out_eob_q;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q  <= 2'd1;
      act_q <= 4'd2;
    end else if (cfg_we) begin
      case (pfi_reg_e'(paddr[2]))
        REG_FACTOR_SHIFT:    fs_q  <= pwdata[1:0];
        REG_ACTIVE_CHANNELS: act_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (pfi_reg_e'(paddr[2]))
      REG_FACTOR_SHIFT:    prdata = {30'd0, fs_q};
      REG_ACTIVE_CHANNELS: prdata = {28'd0, act_q};
      default:             prdata = '0;
    endcase
  end

  assign eff_shift  = (int'(fs_q) > MAX_SHIFT) ? 2'(MAX_SHIFT) : fs_q;
  assign act_lim    = ({1'b0, act_q} > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : {1'b0, act_q};
  assign in_active  = {2'b00, s_axis_tuser} < act_lim;
  assign accept     = s_axis_tvalid & s_axis_tready;
  assign last_phase = bypass_q || (phase_q == PHASE_W'((4'd1 << eff_shift) - 4'd1));
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  assign pos      = wp_q[CH_W'(ch_q)];
  assign pos_next = (pos == IDX_W'(PL - 1)) ? '0 : pos + 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_active) begin
          state_d = (eff_shift == 2'd0) ? ST_EMIT : ST_WRITE;
        end
      end
      ST_WRITE: state_d = ST_MAC;
      ST_MAC: begin
        if (j_q == IDX_W'(PL - 1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!mac_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) state_d = last_phase ? ST_IDLE : ST_MAC;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready  = (state_q == ST_IDLE);
    hist_we        = (state_q == ST_WRITE);
    mac_ctrl.issue = (state_q == ST_MAC);
    mac_ctrl.clr   = (state_q == ST_WRITE) || (out_load && !last_phase);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Ring pointers and read counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CHANNELS; c++) wp_q[c] <= '0;
      idx_q      <= '0;
      start_q    <= '0;
      j_q        <= '0;
      base_q     <= '0;
      tap_addr_q <= '0;
      phase_q    <= '0;
      bypass_q   <= 1'b0;
    end else if (cfg_we) begin
      for (int c = 0; c < MAX_CHANNELS; c++) wp_q[c] <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            base_q   <= AW'(AW'(s_axis_tuser) * AW'(PL));
            bypass_q <= (eff_shift == 2'd0);
            phase_q  <= '0;
          end
        end
        ST_WRITE: begin
          wp_q[CH_W'(ch_q)] <= pos_next;
          start_q    <= pos_next;
          idx_q      <= pos_next;
          j_q        <= '0;
          tap_addr_q <= '0;
        end
        ST_MAC: begin
          idx_q      <= (idx_q == IDX_W'(PL - 1)) ? '0 : idx_q + 1'b1;
          j_q        <= j_q + 1'b1;
          tap_addr_q <= tap_addr_q + 1'b1;
        end
        ST_EMIT: begin
          if (out_load && !last_phase) begin
            phase_q <= phase_q + 1'b1;
            idx_q   <= start_q;
            j_q     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q     <= s_axis_tuser;
      sample_q <= s_axis_tdata;
      eob_q    <= s_axis_tlast;
    end
  end

  pfi_hist_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (cfg_we),
    .we_i    (hist_we),
    .waddr_i (base_q + AW'(pos)),
    .wdata_i (sample_q),
    .raddr_i (base_q + AW'(idx_q)),
    .rdata_o (hist_rdata)
  );

  pfi_tap_rom #(
    .TAPS_PER_PHASE (TAPS_PER_PHASE),
    .MAX_SHIFT      (MAX_SHIFT),
    .ADDR_W         (TAW)
  ) u_rom (
    .clk_i   (clk_i),
    .shift_i (eff_shift),
    .addr_i  (tap_addr_q),
    .tap_o   (tap)
  );

  pfi_mac #(
    .TAPS_PER_PHASE (TAPS_PER_PHASE)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .shift_i  (eff_shift),
    .sample_i (hist_rdata),
    .tap_i    (tap),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= bypass_q ? sample_q : mac_result;
      out_ch_q     <= ch_q;
      out_phase_q  <= phase_q;
      out_last_q   <= last_phase;
      out_eob_q    <= last_phase & eob_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = {out_eob_q, out_phase_q, out_ch_q};
  assign m_axis_tlast  = out_last_q;

endmodule
